// ===== rtl/qte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the CORDIC angle table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    localparam int CW    = 38;
    localparam int ZW    = 32;
    localparam int ANG_W = 18;
    localparam int SQ_W  = 56;
    localparam int RT_W  = 29;
    localparam int SQRT_STEPS = 29;

    typedef logic signed [CW-1:0]    cw_t;
    typedef logic signed [ZW-1:0]    zw_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam zw_t PI_Q28      = 32'sd843314857;
    localparam int  PI_Q13      = 25736;
    localparam int  HALF_PI_Q13 = 12868;

    function automatic zw_t atan_q28(input int unsigned i);
        zw_t a;
        case (i)
            0:       a = 32'sd210828714;
            1:       a = 32'sd124459457;
            2:       a = 32'sd65760959;
            3:       a = 32'sd33381290;
            4:       a = 32'sd16755422;
            5:       a = 32'sd8385879;
            6:       a = 32'sd4193963;
            7:       a = 32'sd2097109;
            8:       a = 32'sd1048571;
            9:       a = 32'sd524287;
            10:      a = 32'sd262144;
            11:      a = 32'sd131072;
            12:      a = 32'sd65536;
            13:      a = 32'sd32768;
            14:      a = 32'sd16384;
            15:      a = 32'sd8192;
            16:      a = 32'sd4096;
            17:      a = 32'sd2048;
            18:      a = 32'sd1024;
            19:      a = 32'sd512;
            20:      a = 32'sd256;
            21:      a = 32'sd128;
            22:      a = 32'sd64;
            23:      a = 32'sd32;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qte_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root of 2^56 - sq, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [SQ_W-1:0] sq,
    output logic      [RT_W-1:0] root
);

    logic [SQ_W:0]   n_reg [0:SQRT_STEPS];
    logic [SQ_W+1:0] r_reg [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0] <= {1'b1, {SQ_W{1'b0}}} - {1'b0, sq};
            r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQ_W+1:0] BIT = (SQ_W+2)'(1) << (SQ_W - 2*k);
        logic [SQ_W+1:0] t;
        assign t = r_reg[k] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, n_reg[k]} >= t) begin
                    n_reg[k+1] <= n_reg[k] - t[SQ_W:0];
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end else begin
                    n_reg[k+1] <= n_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign root = r_reg[SQRT_STEPS][RT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/qte_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// Unrolled vectoring CORDIC: atan2(y, x) at Q28, rounded to Q13.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
    input  wire logic aclk,
    input  wire logic en,
    input  wire cw_t  y_in,
    input  wire cw_t  x_in,
    output ang_t      angle
);

    cw_t x_reg [0:CORDIC_N];
    cw_t y_reg [0:CORDIC_N];
    zw_t z_reg [0:CORDIC_N];
    logic signed [ZW:0] z_rnd;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_in < 0) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? PI_Q28 : -PI_Q28;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
        localparam zw_t ANG = atan_q28(i);
        cw_t xs;
        cw_t ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ANG;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
            end
        end
    end

    assign z_rnd = (ZW+1)'(z_reg[CORDIC_N]) + (ZW+1)'(1 << 14);
    assign angle = ang_t'(z_rnd >>> 15);

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// ZYX roll and yaw in Q3.13 and pitch in Q2.13 from a unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one quaternion per transaction: s_tdata holds w, x, y,
//   z as 16-bit signed Q2.14 words, w in the lowest bits.
//   m_ channel returns one transaction per quaternion: roll and yaw (16 bits,
//   Q3.13) and pitch (15 bits, Q2.13) in m_tdata, and in m_tuser a flag
//   that is set when the pitch sine reached one and pitch was clamped.
//   The pipeline has three product and sum stages, thirty square root
//   stages, the CORDIC pre-rotation plus one stage per CORDIC iteration,
//   and the output register. Throughput is one transaction per cycle
//   unless the receiver stalls; every stage holds one item.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
    output logic [0:0]       m_tuser   // pitch_clamped
);

    localparam int SIDE_LEN  = SQRT_STEPS + 2;
    localparam int CORD_LEN  = CORDIC_N + 1;
    localparam int VLD_DEPTH = 2 + SIDE_LEN + CORD_LEN + 1;

    typedef struct packed {
        cw_t               sr;
        cw_t               cr;
        cw_t               sy;
        cw_t               cy;
        logic signed [28:0] sp;
        logic              clamp;
        logic              neg;
    } side_t;

    typedef struct packed {
        logic clamp;
        logic neg;
    } pflag_t;

    logic en;
    logic [VLD_DEPTH-1:0] vld_reg;

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;
    side_t side_reg;
    cw_t   sp_full;
    logic [27:0] sp_mag;
    logic [SQ_W-1:0] sq_reg;
    side_t side_dly_reg [0:SIDE_LEN-1];
    pflag_t pf_dly_reg [0:CORD_LEN-1];
    logic [RT_W-1:0] root;
    ang_t roll_a, pitch_a, yaw_a;

    logic [15:0] roll_reg, yaw_reg;
    logic [14:0] pitch_reg;
    logic        flag_reg;
    logic [15:0] roll_next, yaw_next;
    logic [14:0] pitch_next;

    assign en       = !vld_reg[VLD_DEPTH-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[31:16]);
            yz_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[63:48]);
            xx_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
            yy_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[47:32]);
            wy_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[47:32]);
            zx_reg <= $signed(s_tdata[63:48]) * $signed(s_tdata[31:16]);
            wz_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[63:48]);
            xy_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[47:32]);
            zz_reg <= $signed(s_tdata[63:48]) * $signed(s_tdata[63:48]);
        end
    end

    assign sp_full = (CW'(wy_reg) - CW'(zx_reg)) <<< 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg.sr    <= (CW'(wx_reg) + CW'(yz_reg)) <<< 1;
            side_reg.cr    <= (CW'(1) <<< 28) - ((CW'(xx_reg) + CW'(yy_reg)) <<< 1);
            side_reg.sy    <= (CW'(wz_reg) + CW'(xy_reg)) <<< 1;
            side_reg.cy    <= (CW'(1) <<< 28) - ((CW'(yy_reg) + CW'(zz_reg)) <<< 1);
            side_reg.clamp <= (sp_full >= (CW'(1) <<< 28)) || (sp_full <= -(CW'(1) <<< 28));
            side_reg.neg   <= sp_full < 0;
            if ((sp_full >= (CW'(1) <<< 28)) || (sp_full <= -(CW'(1) <<< 28))) begin
                side_reg.sp <= '0;
            end else begin
                side_reg.sp <= sp_full[28:0];
            end
        end
    end

    assign sp_mag = side_reg.sp[28] ? 28'(-side_reg.sp) : side_reg.sp[27:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg          <= sp_mag * sp_mag;
            side_dly_reg[0] <= side_reg;
            for (int k = 1; k < SIDE_LEN; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    qte_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .sq   (sq_reg),
        .root (root)
    );

    qte_cordic u_roll (
        .aclk  (aclk),
        .en    (en),
        .y_in  (side_dly_reg[SIDE_LEN-1].sr),
        .x_in  (side_dly_reg[SIDE_LEN-1].cr),
        .angle (roll_a)
    );

    qte_cordic u_pitch (
        .aclk  (aclk),
        .en    (en),
        .y_in  (CW'(side_dly_reg[SIDE_LEN-1].sp)),
        .x_in  (CW'({1'b0, root})),
        .angle (pitch_a)
    );

    qte_cordic u_yaw (
        .aclk  (aclk),
        .en    (en),
        .y_in  (side_dly_reg[SIDE_LEN-1].sy),
        .x_in  (side_dly_reg[SIDE_LEN-1].cy),
        .angle (yaw_a)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            pf_dly_reg[0].clamp <= side_dly_reg[SIDE_LEN-1].clamp;
            pf_dly_reg[0].neg   <= side_dly_reg[SIDE_LEN-1].neg;
            for (int k = 1; k < CORD_LEN; k++) begin
                pf_dly_reg[k] <= pf_dly_reg[k-1];
            end
        end
    end

    always_comb begin
        if (roll_a > ANG_W'(PI_Q13)) begin
            roll_next = 16'(PI_Q13);
        end else if (roll_a < -ANG_W'(PI_Q13)) begin
            roll_next = 16'(-PI_Q13);
        end else begin
            roll_next = roll_a[15:0];
        end
        if (yaw_a > ANG_W'(PI_Q13)) begin
            yaw_next = 16'(PI_Q13);
        end else if (yaw_a < -ANG_W'(PI_Q13)) begin
            yaw_next = 16'(-PI_Q13);
        end else begin
            yaw_next = yaw_a[15:0];
        end
        if (pf_dly_reg[CORD_LEN-1].clamp) begin
            pitch_next = pf_dly_reg[CORD_LEN-1].neg ? 15'(-HALF_PI_Q13) : 15'(HALF_PI_Q13);
        end else if (pitch_a > ANG_W'(HALF_PI_Q13)) begin
            pitch_next = 15'(HALF_PI_Q13);
        end else if (pitch_a < -ANG_W'(HALF_PI_Q13)) begin
            pitch_next = 15'(-HALF_PI_Q13);
        end else begin
            pitch_next = pitch_a[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            flag_reg  <= pf_dly_reg[CORD_LEN-1].clamp;
        end
    end

    assign m_tvalid = vld_reg[VLD_DEPTH-1];
    assign m_tdata  = {1'b0, yaw_reg, pitch_reg, roll_reg};
    assign m_tuser  = flag_reg;

`ifndef SYNTHESIS
    localparam logic [14:0] P_POS = 15'(HALF_PI_Q13);
    localparam logic [14:0] P_NEG = 15'(-HALF_PI_Q13);

    a_clamp_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[30:16] == P_POS || m_tdata[30:16] == P_NEG)
        else $error("clamped pitch not at half pi");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd25736
                     && $signed(m_tdata[15:0]) >= -16'sd25736)
        else $error("roll out of range");
`endif

endmodule
`default_nettype wire
